[rtl/ppe_pkg.sv]
package ppe_pkg;

    localparam int POOL_SIZE = 32;
    localparam int IDX_W = $clog2(POOL_SIZE);
    localparam int CNT_W = $clog2(POOL_SIZE + 1);

    // Request codes on req_type
    localparam logic REQ_SPAWN = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    // Per-slot record: pos x/y, vel x/y, grav x/y, life, max life, side, rgb, base alpha
    localparam int REC_W = 32 * 6 + 31 + 31 + 31 + 24 + 8;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] gx;
        logic signed [31:0] gy;
        logic [30:0]        life;
        logic [30:0]        max_life;
        logic [30:0]        side;
        logic [23:0]        rgb;
        logic [7:0]         base;
    } rec_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_WAIT,
        ST_VEL,
        ST_POS,
        ST_CHK,
        ST_MOVE_RD,
        ST_MOVE_WAIT,
        ST_EMIT_RD,
        ST_EMIT_WAIT,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic ld_rec;
        logic do_vel;
        logic do_pos;
        logic div_start;
    } dp_cmd_t;

    typedef struct packed {
        logic dead;
        logic div_done;
    } dp_sts_t;

    // Clamp a 35-bit sum into the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        if (v > 35'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -35'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

endpackage

[rtl/ppe_ram.sv]
module ppe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/ppe_datapath.sv]
module ppe_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  ppe_pkg::dp_cmd_t    cmd,
    output ppe_pkg::dp_sts_t    sts,
    input  ppe_pkg::rec_t       rd_rec,
    input  logic [17:0]         dt,
    output ppe_pkg::rec_t       cur,
    output logic [7:0]          alpha
);

    ppe_pkg::rec_t     cur_reg;
    ppe_pkg::rec_t     cur_next;

    // Restoring divider: q = (2*base*life + mx) / (2*mx)
    logic [40:0]       rem_reg;
    logic [40:0]       num_reg;
    logic [31:0]       den_reg;
    logic [40:0]       quo_reg;
    logic [5:0]        bit_reg;
    logic              busy_reg;
    logic              done_reg;

    logic signed [50:0] pgx, pgy, pvx, pvy;
    logic signed [33:0] lsub;

    always_comb
    begin
        pgx = cur_reg.gx * $signed({1'b0, dt});
        pgy = cur_reg.gy * $signed({1'b0, dt});
        pvx = cur_reg.vx * $signed({1'b0, dt});
        pvy = cur_reg.vy * $signed({1'b0, dt});
        lsub = $signed({3'b0, cur_reg.life}) - $signed({16'b0, dt});
        cur_next = cur_reg;
        if (cmd.ld_rec)
        begin
            cur_next = rd_rec;
        end
        else if (cmd.do_vel)
        begin
            // Arithmetic shift floors toward minus infinity
            cur_next.vx = ppe_pkg::sat32($signed({{3{cur_reg.vx[31]}}, cur_reg.vx})
                                         + $signed(pgx[50:16]));
            cur_next.vy = ppe_pkg::sat32($signed({{3{cur_reg.vy[31]}}, cur_reg.vy})
                                         + $signed(pgy[50:16]));
        end
        else if (cmd.do_pos)
        begin
            cur_next.px = ppe_pkg::sat32($signed({{3{cur_reg.px[31]}}, cur_reg.px})
                                         + $signed(pvx[50:16]));
            cur_next.py = ppe_pkg::sat32($signed({{3{cur_reg.py[31]}}, cur_reg.py})
                                         + $signed(pvy[50:16]));
            cur_next.life = (lsub <= 0) ? 31'd0 : lsub[30:0];
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

    // Shift-subtract divide, one quotient bit a cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            bit_reg  <= '0;
            num_reg  <= '0;
            den_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.div_start)
            begin
                busy_reg <= (cur_reg.max_life != 31'd0);
                done_reg <= (cur_reg.max_life == 31'd0);
                num_reg  <= ({33'd0, cur_reg.base} * {10'd0, cur_reg.life}) * 41'd2
                            + {10'd0, cur_reg.max_life};
                den_reg  <= {cur_reg.max_life, 1'b0};
                rem_reg  <= '0;
                quo_reg  <= '0;
                bit_reg  <= 6'd41;
            end
            else if (busy_reg)
            begin
                if ({rem_reg, num_reg[40]} >= {10'd0, den_reg})
                begin
                    rem_reg <= 41'({rem_reg, num_reg[40]} - {10'd0, den_reg});
                    quo_reg <= {quo_reg[39:0], 1'b1};
                end
                else
                begin
                    rem_reg <= {rem_reg[39:0], num_reg[40]};
                    quo_reg <= {quo_reg[39:0], 1'b0};
                end
                num_reg <= {num_reg[39:0], 1'b0};
                bit_reg <= bit_reg - 6'd1;
                if (bit_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign cur   = cur_reg;
    assign alpha = (quo_reg > 41'd255) ? 8'd255 : quo_reg[7:0];
    assign sts.dead     = (cur_reg.life == 31'd0);
    assign sts.div_done = done_reg;

endmodule

[rtl/ppe_ctrl.sv]
module ppe_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         req_type,
    input  logic [17:0]                  dt_in,
    output logic [17:0]                  dt,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         last,
    output ppe_pkg::dp_cmd_t             cmd,
    input  ppe_pkg::dp_sts_t             sts,
    output logic                         we,
    output logic                         wsel_in,
    output logic [ppe_pkg::IDX_W-1:0]    waddr,
    output logic [ppe_pkg::IDX_W-1:0]    raddr,
    output logic [ppe_pkg::CNT_W-1:0]    count
);

    ppe_pkg::state_t             state_reg, state_next;
    logic [ppe_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [ppe_pkg::CNT_W-1:0]   idx_reg, idx_next;
    logic [17:0]                 dt_reg, dt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ppe_pkg::ST_IDLE;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            dt_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            dt_reg    <= dt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        dt_next    = dt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        we         = 1'b0;
        wsel_in    = 1'b0;
        waddr      = idx_reg[ppe_pkg::IDX_W-1:0];
        raddr      = idx_reg[ppe_pkg::IDX_W-1:0];
        case (state_reg)
            ppe_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                waddr    = cnt_reg[ppe_pkg::IDX_W-1:0];
                wsel_in  = 1'b1;
                if (in_valid)
                begin
                    if (req_type == ppe_pkg::REQ_SPAWN)
                    begin
                        // Append, drop when full
                        if (cnt_reg < ppe_pkg::CNT_W'(ppe_pkg::POOL_SIZE))
                        begin
                            we       = 1'b1;
                            cnt_next = cnt_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        dt_next    = dt_in;
                        idx_next   = '0;
                        state_next = ppe_pkg::ST_RD;
                    end
                end
            end
            ppe_pkg::ST_RD:
            begin
                if (idx_reg >= cnt_reg)
                begin
                    idx_next   = '0;
                    state_next = ppe_pkg::ST_EMIT_RD;
                end
                else
                begin
                    state_next = ppe_pkg::ST_WAIT;
                end
            end
            ppe_pkg::ST_WAIT:
            begin
                cmd.ld_rec = 1'b1;
                state_next = ppe_pkg::ST_VEL;
            end
            ppe_pkg::ST_VEL:
            begin
                cmd.do_vel = 1'b1;
                state_next = ppe_pkg::ST_POS;
            end
            ppe_pkg::ST_POS:
            begin
                cmd.do_pos = 1'b1;
                state_next = ppe_pkg::ST_CHK;
            end
            ppe_pkg::ST_CHK:
            begin
                if (sts.dead)
                begin
                    // Pull last particle into this slot and step it here
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = ppe_pkg::ST_MOVE_RD;
                end
                else
                begin
                    we         = 1'b1;
                    idx_next   = idx_reg + 1'b1;
                    state_next = ppe_pkg::ST_RD;
                end
            end
            ppe_pkg::ST_MOVE_RD:
            begin
                raddr = cnt_reg[ppe_pkg::IDX_W-1:0];
                if (idx_reg >= cnt_reg)
                begin
                    idx_next   = '0;
                    state_next = ppe_pkg::ST_EMIT_RD;
                end
                else
                begin
                    state_next = ppe_pkg::ST_WAIT;
                end
            end
            ppe_pkg::ST_EMIT_RD:
            begin
                if (idx_reg >= cnt_reg)
                begin
                    state_next = ppe_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = ppe_pkg::ST_EMIT_WAIT;
                end
            end
            ppe_pkg::ST_EMIT_WAIT:
            begin
                cmd.ld_rec = 1'b1;
                state_next = ppe_pkg::ST_DIV;
            end
            ppe_pkg::ST_DIV:
            begin
                cmd.div_start = 1'b1;
                state_next    = ppe_pkg::ST_MOVE_WAIT;
            end
            ppe_pkg::ST_MOVE_WAIT:
            begin
                if (sts.div_done)
                begin
                    state_next = ppe_pkg::ST_OUT;
                end
            end
            ppe_pkg::ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ppe_pkg::ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = ppe_pkg::ST_IDLE;
            end
        endcase
    end

    assign dt    = dt_reg;
    assign last  = (idx_reg + 1'b1 == cnt_reg);
    assign count = cnt_reg;

endmodule

[rtl/particle_pool_euler_step.sv]
// Spawn: accepted in idle, no result.
// Tick: each particle is read, loaded, velocity-stepped, position-stepped and checked (a particle
// moved into a freed slot is stepped again), then each survivor is read, loaded, divided for alpha
// (41 quotient bits) and held on the output until taken; the walk then returns to idle.
// One item at a time: input is held off until the last square of a tick is taken.
// Reset clears the live count, controller and divider; the particle RAM is not cleared.
module particle_pool_euler_step (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               req_type,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] vel_x,
    input  logic signed [31:0] vel_y,
    input  logic signed [31:0] grav_x,
    input  logic signed [31:0] grav_y,
    input  logic [30:0]        life_init,
    input  logic [30:0]        side_len,
    input  logic [23:0]        color_rgb,
    input  logic [7:0]         base_alpha,
    input  logic [17:0]        dt,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] rect_x,
    output logic signed [31:0] rect_y,
    output logic [30:0]        rect_side,
    output logic [23:0]        rgb_out,
    output logic [7:0]         alpha_out,
    output logic               last
);

    ppe_pkg::dp_cmd_t            cmd;
    ppe_pkg::dp_sts_t            sts;
    ppe_pkg::rec_t               rd_rec, cur, in_rec, wr_rec;
    logic                        we, wsel_in;
    logic [ppe_pkg::IDX_W-1:0]   waddr, raddr;
    logic [ppe_pkg::CNT_W-1:0]   count;
    logic [17:0]                 dt_q;
    logic [7:0]                  alpha;

    assign in_rec = '{px: pos_x, py: pos_y, vx: vel_x, vy: vel_y, gx: grav_x,
                      gy: grav_y, life: life_init, max_life: life_init,
                      side: side_len, rgb: color_rgb, base: base_alpha};
    assign wr_rec = wsel_in ? in_rec : cur;

    ppe_ram #(.WIDTH(ppe_pkg::REC_W), .DEPTH(ppe_pkg::POOL_SIZE)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wr_rec),
        .raddr (raddr),
        .rdata (rd_rec)
    );

    ppe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .dt_in     (dt),
        .dt        (dt_q),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .last      (last),
        .cmd       (cmd),
        .sts       (sts),
        .we        (we),
        .wsel_in   (wsel_in),
        .waddr     (waddr),
        .raddr     (raddr),
        .count     (count)
    );

    ppe_datapath u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .sts    (sts),
        .rd_rec (rd_rec),
        .dt     (dt_q),
        .cur    (cur),
        .alpha  (alpha)
    );

    // Square corner: position minus half side, saturated
    assign rect_x    = ppe_pkg::sat32($signed({{3{cur.px[31]}}, cur.px})
                                      - $signed({5'b0, cur.side[30:1]}));
    assign rect_y    = ppe_pkg::sat32($signed({{3{cur.py[31]}}, cur.py})
                                      - $signed({5'b0, cur.side[30:1]}));
    assign rect_side = cur.side;
    assign rgb_out   = cur.rgb;
    assign alpha_out = alpha;

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count <= ppe_pkg::CNT_W'(ppe_pkg::POOL_SIZE))
        else $error("live count above pool size");
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken during output");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(rect_x))
        else $error("result changed while stalled");

endmodule
